/* sv/pwm_divider_wrap_solver_macros.svh */
// ----------------------------------------------------------------------------
// pwm divider wrap solver assertion macros
// shared concurrent assertion wrappers, compiled out with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef PWM_DIVIDER_WRAP_SOLVER_MACROS_SVH
`define PWM_DIVIDER_WRAP_SOLVER_MACROS_SVH

`ifndef ASSERT_OFF
`define PWD_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("pwd assertion failed");
`define PWD_ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("pwd assertion failed");
`else
`define PWD_ASSERT(lbl, clk, rst_n, prop)
`define PWD_ASSERT_IMPL(lbl, clk, rst_n, pre, post)
`endif

`endif

/* sv/pwd_pkg.sv */
// ----------------------------------------------------------------------------
// pwd_pkg
// widths, limits and shared types of the pwm divider wrap solver
// ----------------------------------------------------------------------------
package pwd_pkg;

	localparam int HZ_W        = 29;
	localparam int DUTY_W      = 7;
	localparam int FRAC_BITS   = 4;
	localparam int DIVI_W      = 8;
	localparam int DIV_W       = DIVI_W + FRAC_BITS;
	localparam int PERIOD_LOG2 = 16;
	localparam int PERIOD_W    = PERIOD_LOG2 + 1;
	localparam int WRAP_W      = 16;

	localparam int DEN1_SHIFT  = PERIOD_LOG2 - FRAC_BITS;
	localparam int DIV1_BITS   = DIV_W;

	localparam logic [DIV_W-1:0]    DIV_MIN    = DIV_W'(1 << FRAC_BITS);
	localparam logic [DIV_W-1:0]    DIV_MAX    = DIV_W'(255 << FRAC_BITS);
	localparam logic [PERIOD_W-1:0] PERIOD_MAX = PERIOD_W'(1 << PERIOD_LOG2);
	localparam logic [PERIOD_W-1:0] PERIOD_MIN = PERIOD_W'(2);
	localparam logic [DUTY_W-1:0]   DUTY_FULL  = DUTY_W'(100);
	localparam logic [HZ_W-1:0]     SYSCLK_RESET = HZ_W'(150000000);

	// floor(x / 100) = (x * RECIP) >> RECIP_SHIFT for x below 2^23
	localparam int                  RECIP_SHIFT = 30;
	localparam int                  LVL_X_W     = 24;
	localparam logic [23:0]         RECIP       = 24'd10737419;

	typedef struct packed {
		logic en;
		logic valid;
	} pwd_ctl_t;

endpackage

/* sv/pwd_level_calc.sv */
// ----------------------------------------------------------------------------
// pwd_level_calc
// period clamp, compare level by reciprocal multiply, output register
// ----------------------------------------------------------------------------
module pwd_level_calc (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pwd_pkg::pwd_ctl_t             ctl,
	input  logic [pwd_pkg::PERIOD_W-1:0]  quotient,
	input  logic                          overflow,
	input  logic [pwd_pkg::DIV_W-1:0]     div,
	input  logic [pwd_pkg::DUTY_W-1:0]    duty,
	output logic                          out_valid,
	output logic [pwd_pkg::DIVI_W-1:0]    divider_integer,
	output logic [pwd_pkg::FRAC_BITS-1:0] divider_fraction,
	output logic [pwd_pkg::WRAP_W-1:0]    wrap_value,
	output logic [pwd_pkg::PERIOD_W-1:0]  compare_level
);
	import pwd_pkg::*;

	localparam int Y_W = LVL_X_W + 24;

	logic                  v_s1, v_s2, v_s3;
	logic [PERIOD_W-1:0]   period_s1, period_s2, period_s3;
	logic [DIV_W-1:0]      div_s1, div_s2, div_s3;
	logic [DUTY_W-1:0]     duty_s1;
	logic [LVL_X_W-1:0]    x_s2;
	logic [Y_W-1:0]        y_s3;
	logic [PERIOD_W-1:0]   period_c;

	always_comb begin
		if (overflow || quotient > PERIOD_MAX) begin
			period_c = PERIOD_MAX;
		end else if (quotient < PERIOD_MIN) begin
			period_c = PERIOD_MIN;
		end else begin
			period_c = quotient;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			out_valid <= 1'b0;
		end else if (ctl.en) begin
			v_s1      <= ctl.valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			out_valid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			period_s1 <= period_c;
			div_s1    <= div;
			duty_s1   <= duty;
			x_s2      <= LVL_X_W'(period_s1) * LVL_X_W'(duty_s1);
			period_s2 <= period_s1;
			div_s2    <= div_s1;
			y_s3      <= Y_W'(x_s2) * Y_W'(RECIP);
			period_s3 <= period_s2;
			div_s3    <= div_s2;
			divider_integer  <= div_s3[DIV_W-1:FRAC_BITS];
			divider_fraction <= div_s3[FRAC_BITS-1:0];
			wrap_value       <= WRAP_W'(period_s3 - PERIOD_W'(1));
			compare_level    <= y_s3[RECIP_SHIFT +: PERIOD_W];
		end
	end

endmodule

/* sv/pwm_divider_wrap_solver.sv */
// ----------------------------------------------------------------------------
// pwm_divider_wrap_solver
// pwm clock divider, wrap and compare level from frequency and duty
// ----------------------------------------------------------------------------
// Accepts one request per clock while the output is not stalled and returns one
// result per request, in order. Two restoring dividers retire one quotient bit
// per stage: 13 stages for the 8.4 divider (one range check plus 12 bits),
// 3 stages for the clamp, hz * div product and the period dividend, 18 for the
// period (one range check plus 17 bits), followed by the 4 stages of the level
// calculation. The whole pipeline holds while a result waits at the output,
// so in_ready follows out_ready when the output is full.
// Write system_clock_hz only while no request is in flight.
`include "pwm_divider_wrap_solver_macros.svh"

module pwm_divider_wrap_solver (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write_en,
	input  logic [pwd_pkg::HZ_W-1:0]      cfg_write_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [pwd_pkg::HZ_W-1:0]      target_hz,
	input  logic [pwd_pkg::DUTY_W-1:0]    duty_percent,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [pwd_pkg::DIVI_W-1:0]    divider_integer,
	output logic [pwd_pkg::FRAC_BITS-1:0] divider_fraction,
	output logic [pwd_pkg::WRAP_W-1:0]    wrap_value,
	output logic [pwd_pkg::PERIOD_W-1:0]  compare_level
);
	import pwd_pkg::*;

	localparam int W1   = HZ_W + DEN1_SHIFT + DIV1_BITS;
	localparam int DEN_W = HZ_W + DIV_W;
	localparam int N_W   = DEN_W + 1;
	localparam int Q2_W  = PERIOD_W;
	localparam int W2    = N_W + Q2_W;

	logic [HZ_W-1:0]   sysclk_q;
	logic              adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sysclk_q <= SYSCLK_RESET;
		end else if (cfg_write_en) begin
			sysclk_q <= cfg_write_data;
		end
	end

	assign adv      = ~out_valid | out_ready;
	assign in_ready = adv;

	// first divider: floor(sysclk / (hz << 12)) and remainder, one quotient bit per stage
	logic [DIV1_BITS:0]  v1;
	logic [HZ_W-1:0]     hz1   [0:DIV1_BITS];
	logic [DUTY_W-1:0]   duty1 [0:DIV1_BITS];
	logic                ovf1  [0:DIV1_BITS];
	logic [HZ_W-1:0]     rem1  [0:DIV1_BITS];
	logic [DIV1_BITS-1:0] q1   [0:DIV1_BITS];

	logic [HZ_W-1:0]   hz_in;
	logic [DUTY_W-1:0] duty_in;

	always_comb begin
		hz_in   = (target_hz == '0) ? HZ_W'(1) : target_hz;
		duty_in = (duty_percent > DUTY_FULL) ? DUTY_FULL : duty_percent;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1 <= '0;
		end else if (adv) begin
			v1 <= {v1[DIV1_BITS-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hz1[0]   <= hz_in;
			duty1[0] <= duty_in;
			ovf1[0]  <= W1'(sysclk_q) >= (W1'(hz_in) << (DEN1_SHIFT + DIV1_BITS));
			rem1[0]  <= sysclk_q;
			q1[0]    <= '0;
		end
	end

	for (genvar g = 1; g <= DIV1_BITS; g++) begin : g_div1
		localparam int SH = DEN1_SHIFT + DIV1_BITS - g;
		logic [W1-1:0] dsh;
		logic          ge;
		assign dsh = W1'(hz1[g-1]) << SH;
		assign ge  = W1'(rem1[g-1]) >= dsh;
		always_ff @(posedge clk) begin
			if (adv) begin
				hz1[g]   <= hz1[g-1];
				duty1[g] <= duty1[g-1];
				ovf1[g]  <= ovf1[g-1];
				rem1[g]  <= ge ? HZ_W'(W1'(rem1[g-1]) - dsh) : rem1[g-1];
				q1[g]    <= q1[g-1] | (DIV1_BITS'(ge) << (DIV1_BITS - g));
			end
		end
	end

	// round up and clamp the divider, then hz * div and the period dividend
	logic [DIV1_BITS:0] ceil_c;
	logic [DIV_W-1:0]   div_c;

	always_comb begin
		ceil_c = {1'b0, q1[DIV1_BITS]} + (DIV1_BITS+1)'(rem1[DIV1_BITS] != '0);
		if (ovf1[DIV1_BITS] || ceil_c > (DIV1_BITS+1)'(DIV_MAX)) begin
			div_c = DIV_MAX;
		end else if (ceil_c < (DIV1_BITS+1)'(DIV_MIN)) begin
			div_c = DIV_MIN;
		end else begin
			div_c = DIV_W'(ceil_c);
		end
	end

	logic              v_s1, v_s2, v_s3;
	logic [HZ_W-1:0]   hz_s1;
	logic [DIV_W-1:0]  div_s1, div_s2, div_s3;
	logic [DUTY_W-1:0] duty_s1, duty_s2, duty_s3;
	logic [DEN_W-1:0]  den_s2;
	logic [N_W-1:0]    num_s3, dnm_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= v1[DIV1_BITS];
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hz_s1   <= hz1[DIV1_BITS];
			div_s1  <= div_c;
			duty_s1 <= duty1[DIV1_BITS];
			den_s2  <= DEN_W'(hz_s1) * DEN_W'(div_s1);
			div_s2  <= div_s1;
			duty_s2 <= duty_s1;
			// period = floor((2 * sysclk * 16 + den) / (2 * den))
			num_s3  <= (N_W'(sysclk_q) << (FRAC_BITS + 1)) + N_W'(den_s2);
			dnm_s3  <= {den_s2, 1'b0};
			div_s3  <= div_s2;
			duty_s3 <= duty_s2;
		end
	end

	// second divider: range check stage, then one quotient bit per stage
	logic [Q2_W:0]     v2;
	logic [N_W-1:0]    rem2  [0:Q2_W];
	logic [N_W-1:0]    dnm2  [0:Q2_W];
	logic              ovf2  [0:Q2_W];
	logic [Q2_W-1:0]   q2    [0:Q2_W];
	logic [DIV_W-1:0]  div2  [0:Q2_W];
	logic [DUTY_W-1:0] duty2 [0:Q2_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2 <= '0;
		end else if (adv) begin
			v2 <= {v2[Q2_W-1:0], v_s3};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem2[0]  <= num_s3;
			dnm2[0]  <= dnm_s3;
			ovf2[0]  <= W2'(num_s3) >= (W2'(dnm_s3) << Q2_W);
			q2[0]    <= '0;
			div2[0]  <= div_s3;
			duty2[0] <= duty_s3;
		end
	end

	for (genvar g = 1; g <= Q2_W; g++) begin : g_div2
		localparam int SH = Q2_W - g;
		logic [W2-1:0] dsh;
		logic          ge;
		assign dsh = W2'(dnm2[g-1]) << SH;
		assign ge  = W2'(rem2[g-1]) >= dsh;
		always_ff @(posedge clk) begin
			if (adv) begin
				rem2[g]  <= ge ? N_W'(W2'(rem2[g-1]) - dsh) : rem2[g-1];
				dnm2[g]  <= dnm2[g-1];
				ovf2[g]  <= ovf2[g-1];
				q2[g]    <= q2[g-1] | (Q2_W'(ge) << SH);
				div2[g]  <= div2[g-1];
				duty2[g] <= duty2[g-1];
			end
		end
	end

	pwd_ctl_t lvl_ctl;
	assign lvl_ctl.en    = adv;
	assign lvl_ctl.valid = v2[Q2_W];

	pwd_level_calc u_level (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctl              (lvl_ctl),
		.quotient         (q2[Q2_W]),
		.overflow         (ovf2[Q2_W]),
		.div              (div2[Q2_W]),
		.duty             (duty2[Q2_W]),
		.out_valid        (out_valid),
		.divider_integer  (divider_integer),
		.divider_fraction (divider_fraction),
		.wrap_value       (wrap_value),
		.compare_level    (compare_level)
	);

	`PWD_ASSERT(a_ready_follows_output, clk, arst_n, in_ready == (!out_valid || out_ready))
	`PWD_ASSERT_IMPL(a_divider_in_range, clk, arst_n, out_valid, divider_integer != '0)
	`PWD_ASSERT_IMPL(a_wrap_nonzero, clk, arst_n, out_valid, wrap_value != '0)
	`PWD_ASSERT_IMPL(a_level_in_period, clk, arst_n, out_valid, compare_level <= (PERIOD_W'(wrap_value) + PERIOD_W'(1)))

endmodule

/* bench/tb_pwm_divider_wrap_solver.sv */
// ----------------------------------------------------------------------------
// tb_pwm_divider_wrap_solver
// drives frequency and duty requests with random idling on both sides and
// checks each divider, wrap and compare level against an exact integer solver
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_pwm_divider_wrap_solver;
	import pwd_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 60;

	typedef struct packed {
		logic [DIVI_W-1:0]    div_int;
		logic [FRAC_BITS-1:0] div_frac;
		logic [WRAP_W-1:0]    wrap;
		logic [PERIOD_W-1:0]  level;
	} pwm_setting_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_write_en;
	logic [HZ_W-1:0]        cfg_write_data;
	logic                   in_valid;
	logic                   in_ready;
	logic [HZ_W-1:0]        target_hz;
	logic [DUTY_W-1:0]      duty_percent;
	logic                   out_valid;
	logic                   out_ready;
	logic [DIVI_W-1:0]      divider_integer;
	logic [FRAC_BITS-1:0]   divider_fraction;
	logic [WRAP_W-1:0]      wrap_value;
	logic [PERIOD_W-1:0]    compare_level;

	logic [HZ_W-1:0] sysclk_hz;
	pwm_setting_t    pending_settings[$];
	int              error_count = 0;
	int              idle_cycles = 0;
	bit              idling_on;

	pwm_divider_wrap_solver dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.target_hz(target_hz),
		.duty_percent(duty_percent),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.divider_integer(divider_integer),
		.divider_fraction(divider_fraction),
		.wrap_value(wrap_value),
		.compare_level(compare_level)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic pwm_setting_t solve_setting(logic [HZ_W-1:0] hz_in,
			logic [DUTY_W-1:0] duty_in);
		logic [63:0] hz, duty, num, den, div, period, lvl;
		pwm_setting_t s;
		hz = (hz_in == 0) ? 64'd1 : 64'(hz_in);
		duty = (duty_in > DUTY_FULL) ? 64'(DUTY_FULL) : 64'(duty_in);
		num = 64'(sysclk_hz) << FRAC_BITS;
		den = hz << PERIOD_LOG2;
		div = (num + den - 1) / den;
		if (div < 64'(DIV_MIN)) div = 64'(DIV_MIN);
		if (div > 64'(DIV_MAX)) div = 64'(DIV_MAX);
		den = hz * div;
		period = (2 * num + den) / (2 * den);
		if (period < 64'(PERIOD_MIN)) period = 64'(PERIOD_MIN);
		if (period > 64'(PERIOD_MAX)) period = 64'(PERIOD_MAX);
		lvl = (period * duty) / 100;
		s.div_int = div[FRAC_BITS +: DIVI_W];
		s.div_frac = div[FRAC_BITS-1:0];
		s.wrap = WRAP_W'(period - 1);
		s.level = PERIOD_W'(lvl);
		return s;
	endfunction

	// random receiver stalls in bursts
	initial begin
		int n;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (idling_on && $urandom_range(3) == 0) begin
				n = $urandom_range(11, 1);
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
		end
	end

	// result checker
	always @(posedge clk) begin
		pwm_setting_t exp_s;
		if (arst_n && out_valid && out_ready) begin
			if (pending_settings.size() == 0) begin
				$error("unexpected result beat");
				error_count++;
			end else begin
				exp_s = pending_settings.pop_front();
				if (divider_integer !== exp_s.div_int) begin
					$error("divider_integer exp %0d got %0d", exp_s.div_int, divider_integer);
					error_count++;
				end
				if (divider_fraction !== exp_s.div_frac) begin
					$error("divider_fraction exp %0d got %0d", exp_s.div_frac,
						divider_fraction);
					error_count++;
				end
				if (wrap_value !== exp_s.wrap) begin
					$error("wrap_value exp %0d got %0d", exp_s.wrap, wrap_value);
					error_count++;
				end
				if (compare_level !== exp_s.level) begin
					$error("compare_level exp %0d got %0d", exp_s.level, compare_level);
					error_count++;
				end
			end
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else if (arst_n) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	task automatic send_request(logic [HZ_W-1:0] hz, logic [DUTY_W-1:0] duty);
		if (idling_on && $urandom_range(3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(11, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		target_hz <= hz;
		duty_percent <= duty;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_settings.push_back(solve_setting(hz, duty));
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (pending_settings.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_sysclk(logic [HZ_W-1:0] value);
		drain();
		cfg_write_en <= 1'b1;
		cfg_write_data <= value;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		sysclk_hz = value;
		@(posedge clk);
	endtask

	function automatic logic [HZ_W-1:0] rand_hz();
		case ($urandom_range(3))
			0: return HZ_W'($urandom_range(2000, 0));
			1: return HZ_W'($urandom_range(200000, 1));
			2: return HZ_W'($urandom_range(300000000, 1));
			default: return HZ_W'($urandom);
		endcase
	endfunction

	task automatic test_directed;
		send_request(HZ_W'(0), DUTY_W'(50));        // zero frequency
		send_request(HZ_W'(1), DUTY_W'(0));
		send_request({HZ_W{1'b1}}, DUTY_W'(127));   // duty above hundred
		send_request(HZ_W'(300000000), DUTY_W'(100));
		send_request(HZ_W'(1000), DUTY_W'(101));
		send_request(HZ_W'(2289), DUTY_W'(33));
		send_request(HZ_W'(9), DUTY_W'(1));
		send_request(HZ_W'(1000000), DUTY_W'(99));
		send_request(HZ_W'(75000000), DUTY_W'(50));
		send_request(HZ_W'(1 << 28), DUTY_W'(64));
	endtask

	task automatic test_random(int count);
		repeat (count) send_request(rand_hz(), DUTY_W'($urandom));
	endtask

	task automatic test_sysclk_extremes;
		write_sysclk(HZ_W'(0));                     // zero system clock
		test_directed();
		write_sysclk({HZ_W{1'b1}});
		test_directed();
		write_sysclk(HZ_W'(1000000));
		test_random(60);
		write_sysclk(HZ_W'(300000000));
		test_random(60);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_write_en = 1'b0;
		cfg_write_data = '0;
		in_valid = 1'b0;
		target_hz = '0;
		duty_percent = '0;
		idling_on = 1'b1;
		sysclk_hz = SYSCLK_RESET;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(300);
		test_sysclk_extremes();
		write_sysclk(HZ_W'($urandom_range(300000000, 1000000)));
		test_random(200);
		idling_on = 1'b0;
		write_sysclk(SYSCLK_RESET);
		test_random(120);
		drain();
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

/* sim.f */
+incdir+sv
sv/pwd_pkg.sv
sv/pwd_level_calc.sv
sv/pwm_divider_wrap_solver.sv
bench/tb_pwm_divider_wrap_solver.sv
